// ===== sv/srid_pkg.sv =====
// Package for the shared route-id allocator: sizes, function codes,
// sequencer states and the slot entry type. No dependencies.
package srid_pkg;

  localparam int SLOTS       = 16;
  localparam int DIMS        = 5;
  localparam int COORD_BITS  = 6;
  localparam int MAX_SHARERS = 255;

  localparam int IN_BOX_W = 30;
  localparam int BOX_W    = DIMS * COORD_BITS;
  localparam int CHAN_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int MASK_W   = 16;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int SH_W     = $clog2(MAX_SHARERS + 1);

  typedef enum logic [1:0] {
    FUNC_QUERY   = 2'd0,
    FUNC_CLAIM   = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MODIFY,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [BOX_W-1:0]  lo;
    logic [BOX_W-1:0]  hi;
  } entry_t;

endpackage

// ===== sv/shared_route_id_allocator_unit.sv =====
// Shared route-id allocator: slot table, scan sequencer and claim/release logic.
// Depends on srid_pkg.
// Query: slots are scanned in ST_SCAN before the strobe in ST_RESP (one slot
// compared per cycle via the registered table read port); stops early on a hit.
// Claim and release go via ST_MODIFY to the strobe; no-op goes to it directly.
// busy_o stays high through the strobe cycle; a new transfer can land after it.
// Reset clears all sharer counts and the sequencer; box and channel entries
// are unset until claimed and are compared only for occupied slots.
module shared_route_id_allocator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      func_i,
  input  logic [srid_pkg::SLOT_W-1:0]     slot_i,
  input  logic [srid_pkg::CHAN_W-1:0]     channel_i,
  input  logic [srid_pkg::IN_BOX_W-1:0]   box_low_i,
  input  logic [srid_pkg::IN_BOX_W-1:0]   box_high_i,
  output logic                            done_o,
  output logic [srid_pkg::MASK_W-1:0]     slot_mask_o,
  output logic                            edge_flag_o,
  output logic                            fault_o
);

  srid_pkg::state_e state_q, state_d;

  // Request registers
  srid_pkg::func_e                func_q;
  logic [srid_pkg::SLOT_W-1:0]    slot_q;
  srid_pkg::entry_t               req_q;

  // Slot table
  srid_pkg::entry_t               mem [srid_pkg::SLOTS];
  logic [srid_pkg::SH_W-1:0]      sharers_q [srid_pkg::SLOTS];

  // Scan pipeline
  logic [srid_pkg::CNT_W-1:0]     idx_q;
  logic [srid_pkg::IDX_W-1:0]     cmp_idx_q;
  logic                           cmp_vld_q;
  srid_pkg::entry_t               rd_q;
  logic [srid_pkg::SLOTS-1:0]     free_q;

  // Results
  logic [srid_pkg::MASK_W-1:0]    mask_q;
  logic                           edge_q;
  logic                           fault_q;

  logic                           accept;
  logic                           issue;
  logic                           occ;
  logic                           hit;
  logic                           last;
  logic [srid_pkg::SLOTS-1:0]     cmp_bit;
  logic [srid_pkg::SLOTS-1:0]     free_next;
  logic [srid_pkg::IDX_W-1:0]     mod_idx;
  logic [srid_pkg::SH_W-1:0]      mod_cnt;
  logic                           slot_oor;
  logic                           mod_fault;
  logic                           do_write;

  assign accept    = start_i && !busy_o;
  assign issue     = (state_q == srid_pkg::ST_SCAN) &&
                     (idx_q < srid_pkg::CNT_W'(srid_pkg::SLOTS));

  // Shared compare unit: one stored slot against the request per cycle
  assign occ       = sharers_q[cmp_idx_q] != '0;
  assign hit       = cmp_vld_q && occ && (rd_q == req_q);
  assign last      = cmp_idx_q == srid_pkg::IDX_W'(srid_pkg::SLOTS - 1);
  assign cmp_bit   = srid_pkg::SLOTS'(1) << cmp_idx_q;
  assign free_next = (cmp_vld_q && !occ) ? (free_q | cmp_bit) : free_q;

  assign mod_idx   = srid_pkg::IDX_W'(slot_q);
  assign mod_cnt   = sharers_q[mod_idx];
  assign slot_oor  = 32'(slot_q) >= 32'(srid_pkg::SLOTS);
  always_comb begin
    mod_fault = slot_oor;
    if (!slot_oor) begin
      if (func_q == srid_pkg::FUNC_CLAIM) begin
        mod_fault = mod_cnt >= srid_pkg::SH_W'(srid_pkg::MAX_SHARERS);
      end else begin
        mod_fault = mod_cnt == '0;
      end
    end
  end
  assign do_write = (state_q == srid_pkg::ST_MODIFY) && !mod_fault &&
                    (func_q == srid_pkg::FUNC_CLAIM);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srid_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (srid_pkg::func_e'(func_i)) inside
            srid_pkg::FUNC_QUERY:                          state_d = srid_pkg::ST_SCAN;
            srid_pkg::FUNC_CLAIM, srid_pkg::FUNC_RELEASE:  state_d = srid_pkg::ST_MODIFY;
            default:                                       state_d = srid_pkg::ST_RESP;
          endcase
        end
      end
      srid_pkg::ST_SCAN: begin
        if (cmp_vld_q && (hit || last)) begin
          state_d = srid_pkg::ST_RESP;
        end
      end
      srid_pkg::ST_MODIFY: state_d = srid_pkg::ST_RESP;
      srid_pkg::ST_RESP:   state_d = srid_pkg::ST_IDLE;
      default:             state_d = srid_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy_o      = state_q != srid_pkg::ST_IDLE;
    done_o      = state_q == srid_pkg::ST_RESP;
    slot_mask_o = mask_q;
    edge_flag_o = edge_q;
    fault_o     = fault_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= srid_pkg::ST_IDLE;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
      end else begin
        cmp_vld_q <= issue && !hit;
        if (issue) begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  // Sharer counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < srid_pkg::SLOTS; i++) begin
        sharers_q[i] <= '0;
      end
    end else if (state_q == srid_pkg::ST_MODIFY && !mod_fault) begin
      if (func_q == srid_pkg::FUNC_CLAIM) begin
        sharers_q[mod_idx] <= mod_cnt + 1'b1;
      end else begin
        sharers_q[mod_idx] <= mod_cnt - 1'b1;
      end
    end
  end

  // Box and channel table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[mod_idx] <= req_q;
    end
    if (issue) begin
      rd_q      <= mem[idx_q[srid_pkg::IDX_W-1:0]];
      cmp_idx_q <= idx_q[srid_pkg::IDX_W-1:0];
    end
  end

  // Request capture and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q       <= srid_pkg::func_e'(func_i);
      slot_q       <= slot_i;
      req_q.chan   <= channel_i;
      req_q.lo     <= box_low_i[srid_pkg::BOX_W-1:0];
      req_q.hi     <= box_high_i[srid_pkg::BOX_W-1:0];
      free_q       <= '0;
      mask_q       <= '0;
      edge_q       <= 1'b0;
      fault_q      <= 1'b0;
    end else begin
      unique case (state_q)
        srid_pkg::ST_SCAN: begin
          free_q <= free_next;
          if (hit) begin
            mask_q <= srid_pkg::MASK_W'(cmp_bit);
          end else if (cmp_vld_q && last) begin
            mask_q <= srid_pkg::MASK_W'(free_next);
          end
        end
        srid_pkg::ST_MODIFY: begin
          fault_q <= mod_fault;
          if (func_q == srid_pkg::FUNC_CLAIM) begin
            edge_q <= !mod_fault && (mod_cnt == '0);
          end else begin
            edge_q <= !mod_fault && (mod_cnt == srid_pkg::SH_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Checks
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(edge_flag_o && fault_o))
    else $error("edge and fault both set");

  a_query_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && func_q == srid_pkg::FUNC_QUERY) |-> (!edge_flag_o && !fault_o))
    else $error("query result carries flags");

  a_modify_no_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && func_q != srid_pkg::FUNC_QUERY) |-> (slot_mask_o == '0))
    else $error("non-query result carries a mask");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("not busy after transfer");

endmodule

// ===== tb/tb.sv =====
// Testbench for shared_route_id_allocator_unit: drives queries, claims, releases
// and no-ops, keeps a scoreboard of the slot table and checks every result strobe.
// Depends on srid_pkg and the allocator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_ITEMS = 390;

  typedef struct packed {
    logic [srid_pkg::MASK_W-1:0] mask;
    logic                        edge_flag;
    logic                        fault;
  } reply_t;

  // Tracks sharer counts, boxes and channels; holds predicted replies in order.
  class route_slot_book;
    int unsigned                 sharers[srid_pkg::SLOTS];
    logic [srid_pkg::BOX_W-1:0]  low_corner[srid_pkg::SLOTS];
    logic [srid_pkg::BOX_W-1:0]  high_corner[srid_pkg::SLOTS];
    logic [srid_pkg::CHAN_W-1:0] channel[srid_pkg::SLOTS];
    reply_t                      pending_replies[$];
    int                          mismatches;

    function new();
      foreach (sharers[x]) begin
        sharers[x] = 0;
        low_corner[x] = '0;
        high_corner[x] = '0;
        channel[x] = '0;
      end
      mismatches = 0;
    endfunction

    function void log_request(srid_pkg::func_e f, logic [srid_pkg::SLOT_W-1:0] s,
                              logic [srid_pkg::CHAN_W-1:0] c,
                              logic [srid_pkg::IN_BOX_W-1:0] lo,
                              logic [srid_pkg::IN_BOX_W-1:0] hi);
      reply_t                      r;
      logic [srid_pkg::MASK_W-1:0] free_slots;
      bit                          hit;
      r = '0;
      free_slots = '0;
      hit = 1'b0;
      case (f)
        srid_pkg::FUNC_QUERY: begin
          for (int x = 0; x < srid_pkg::SLOTS; x++) begin
            if (!hit) begin
              if (sharers[x] == 0) begin
                if (x < srid_pkg::MASK_W) free_slots[x] = 1'b1;
              end else if (channel[x] == c &&
                           low_corner[x] == lo[srid_pkg::BOX_W-1:0] &&
                           high_corner[x] == hi[srid_pkg::BOX_W-1:0]) begin
                if (x < srid_pkg::MASK_W) r.mask[x] = 1'b1;
                hit = 1'b1;
              end
            end
          end
          if (!hit) r.mask = free_slots;
        end
        srid_pkg::FUNC_CLAIM: begin
          if (s >= srid_pkg::SLOTS || sharers[s] >= srid_pkg::MAX_SHARERS) begin
            r.fault = 1'b1;
          end else begin
            r.edge_flag = (sharers[s] == 0);
            sharers[s]++;
            low_corner[s] = lo[srid_pkg::BOX_W-1:0];
            high_corner[s] = hi[srid_pkg::BOX_W-1:0];
            channel[s] = c;
          end
        end
        srid_pkg::FUNC_RELEASE: begin
          if (s >= srid_pkg::SLOTS || sharers[s] == 0) begin
            r.fault = 1'b1;
          end else begin
            sharers[s]--;
            r.edge_flag = (sharers[s] == 0);
          end
        end
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_response(logic [srid_pkg::MASK_W-1:0] mask, logic edge_flag,
                                 logic fault);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: result with nothing pending: mask %h edge %b fault %b",
                 $time, mask, edge_flag, fault);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      if (mask !== want.mask) begin
        $display("%0t: slot_mask expected %h got %h", $time, want.mask, mask);
        mismatches++;
      end
      if (edge_flag !== want.edge_flag) begin
        $display("%0t: edge_flag expected %b got %b", $time, want.edge_flag, edge_flag);
        mismatches++;
      end
      if (fault !== want.fault) begin
        $display("%0t: fault expected %b got %b", $time, want.fault, fault);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic [1:0]                    func_i = '0;
  logic [srid_pkg::SLOT_W-1:0]   slot_i = '0;
  logic [srid_pkg::CHAN_W-1:0]   channel_i = '0;
  logic [srid_pkg::IN_BOX_W-1:0] box_low_i = '0;
  logic [srid_pkg::IN_BOX_W-1:0] box_high_i = '0;
  logic                          busy_o;
  logic                          done_o;
  logic [srid_pkg::MASK_W-1:0]   slot_mask_o;
  logic                          edge_flag_o;
  logic                          fault_o;

  route_slot_book                book;
  int                            idle_pct = 32;
  int                            quiet_cycles = 0;
  logic [srid_pkg::CHAN_W-1:0]   pool_chan[8];
  logic [srid_pkg::IN_BOX_W-1:0] pool_lo[8];
  logic [srid_pkg::IN_BOX_W-1:0] pool_hi[8];

  shared_route_id_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .slot_i      (slot_i),
    .channel_i   (channel_i),
    .box_low_i   (box_low_i),
    .box_high_i  (box_high_i),
    .done_o      (done_o),
    .slot_mask_o (slot_mask_o),
    .edge_flag_o (edge_flag_o),
    .fault_o     (fault_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) book.check_response(slot_mask_o, edge_flag_o, fault_o);
      if (start_i && !busy_o)
        book.log_request(srid_pkg::func_e'(func_i), slot_i, channel_i, box_low_i,
                         box_high_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Present one request and hold it until the transfer; idle cycles come first.
  task automatic issue(srid_pkg::func_e f, logic [srid_pkg::SLOT_W-1:0] s,
                       logic [srid_pkg::CHAN_W-1:0] c,
                       logic [srid_pkg::IN_BOX_W-1:0] lo,
                       logic [srid_pkg::IN_BOX_W-1:0] hi);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    func_i <= f;
    slot_i <= s;
    channel_i <= c;
    box_low_i <= lo;
    box_high_i <= hi;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Mostly pool boxes so queries hit; some near misses and pure noise.
  task automatic random_request();
    int                            r;
    int                            k;
    int                            b;
    srid_pkg::func_e               f;
    logic [srid_pkg::CHAN_W-1:0]   c;
    logic [srid_pkg::IN_BOX_W-1:0] lo;
    logic [srid_pkg::IN_BOX_W-1:0] hi;
    r = $urandom_range(99);
    k = $urandom_range(7);
    c = pool_chan[k];
    lo = pool_lo[k];
    hi = pool_hi[k];
    if (r < 30) f = srid_pkg::FUNC_QUERY;
    else if (r < 62) f = srid_pkg::FUNC_CLAIM;
    else if (r < 95) f = srid_pkg::FUNC_RELEASE;
    else f = srid_pkg::FUNC_NOP;
    r = $urandom_range(99);
    b = $urandom_range(srid_pkg::IN_BOX_W - 1);
    if (r < 12) begin
      c = srid_pkg::CHAN_W'($urandom);
      lo = srid_pkg::IN_BOX_W'($urandom);
      hi = srid_pkg::IN_BOX_W'($urandom);
    end else if (r < 20) begin
      lo[b] = ~lo[b];
    end else if (r < 28) begin
      hi[b] = ~hi[b];
    end else if (r < 32) begin
      c = c + 1'b1;
    end
    issue(f, srid_pkg::SLOT_W'($urandom_range(15)), c, lo, hi);
  endtask

  initial begin
    book = new();
    for (int k = 0; k < 8; k++) begin
      pool_chan[k] = srid_pkg::CHAN_W'($urandom);
      pool_lo[k] = srid_pkg::IN_BOX_W'($urandom);
      pool_hi[k] = srid_pkg::IN_BOX_W'($urandom);
    end
    pool_chan[0] = '0;
    pool_lo[0] = '0;
    pool_hi[0] = '0;
    pool_chan[1] = '1;
    pool_lo[1] = '1;
    pool_hi[1] = '1;
    // same box as entry 2 on another channel
    pool_lo[3] = pool_lo[2];
    pool_hi[3] = pool_hi[2];
    pool_chan[3] = pool_chan[2] + 1'b1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, fill every slot, hits at both ends, full table,
    // overwrite of an occupied slot, drain and release of an empty slot.
    issue(srid_pkg::FUNC_QUERY, '0, '0, '0, '0);
    issue(srid_pkg::FUNC_NOP, '1, '1, '1, '1);
    issue(srid_pkg::FUNC_CLAIM, 4'd0, pool_chan[0], pool_lo[0], pool_hi[0]);
    for (int s = 1; s < 15; s++)
      issue(srid_pkg::FUNC_CLAIM, srid_pkg::SLOT_W'(s), pool_chan[s % 6 + 2],
            pool_lo[s % 6 + 2], pool_hi[s % 6 + 2]);
    issue(srid_pkg::FUNC_CLAIM, 4'd15, pool_chan[1], pool_lo[1], pool_hi[1]);
    issue(srid_pkg::FUNC_QUERY, '0, pool_chan[1], pool_lo[1], pool_hi[1]);
    issue(srid_pkg::FUNC_QUERY, '0, pool_chan[0], pool_lo[0], pool_hi[0]);
    issue(srid_pkg::FUNC_QUERY, '0, pool_chan[0], pool_lo[1], pool_hi[0]);
    issue(srid_pkg::FUNC_CLAIM, 4'd5, pool_chan[1], pool_lo[1], pool_hi[0]);
    issue(srid_pkg::FUNC_RELEASE, 4'd5, '1, '1, '1);
    issue(srid_pkg::FUNC_RELEASE, 4'd5, '0, '0, '0);
    issue(srid_pkg::FUNC_RELEASE, 4'd5, '0, '0, '0);
    issue(srid_pkg::FUNC_QUERY, '0, pool_chan[0], pool_lo[1], pool_hi[0]);

    for (int n = 0; n < PHASE_ITEMS; n++) random_request();

    idle_pct = 75;
    for (int n = 0; n < PHASE_ITEMS; n++) random_request();
    // Pump one slot past its sharer limit, query it, then drain it past empty.
    repeat (srid_pkg::MAX_SHARERS + 5)
      issue(srid_pkg::FUNC_CLAIM, 4'd9, pool_chan[1], pool_lo[1], pool_hi[1]);
    issue(srid_pkg::FUNC_QUERY, '0, pool_chan[1], pool_lo[1], pool_hi[1]);
    repeat (srid_pkg::MAX_SHARERS + 2) issue(srid_pkg::FUNC_RELEASE, 4'd9, '0, '0, '0);

    idle_pct = 0;
    for (int n = 0; n < PHASE_ITEMS; n++) random_request();
    start_i <= 1'b0;

    while (book.pending_replies.size() != 0) @(posedge clk_i);
    repeat (srid_pkg::SLOTS + 4) @(posedge clk_i);
    if (book.mismatches == 0 && book.pending_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/srid_pkg.sv
sv/shared_route_id_allocator_unit.sv
tb/tb.sv
